/* src/ihss_pkg.sv */
// Package for the image header size sniffer: format codes, tags and fixed constants.
// No dependencies.
package ihss_pkg;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_PNG  = 2'd1,
    FMT_JPEG = 2'd2,
    FMT_WEBP = 2'd3
  } fmt_t;

  localparam logic [31:0] TAG_PNG  = 32'h89504E47;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_CGBI = 32'h43674249;
  localparam logic [15:0] TAG_SOI  = 16'hFFD8;
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WEBP = 32'h57454250;
  localparam logic [31:0] TAG_VP8  = 32'h56503820;
  localparam logic [31:0] TAG_VP8L = 32'h5650384C;
  localparam logic [31:0] TAG_VP8X = 32'h56503858;
  localparam logic [7:0]  MARK_FF  = 8'hFF;
  localparam logic [7:0]  SOF_LO   = 8'hC0;
  localparam logic [7:0]  SOF_HI   = 8'hC2;
  localparam logic [13:0] MASK14   = 14'h3FFF;
  localparam logic [7:0]  VP8X_RSV = 8'hC0;
  localparam logic [7:0]  VP8X_BIT = 8'h01;

  // Result of the last file, handed from the collector to the output stage.
  typedef struct packed {
    fmt_t        fmt;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

endpackage

/* src/ihss_if.sv */
// Valid/ready channel interfaces for the image header size sniffer.
// Depends on nothing.
interface ihss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ihss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  image_format;
  logic [31:0] image_width;
  logic [31:0] image_height;
  modport source (output valid, image_format, image_width, image_height, input ready);
  modport sink   (input valid, image_format, image_width, image_height, output ready);
endinterface

interface ihss_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/image_header_size_sniffer.sv */
// Top level of the image header size sniffer: byte capture, JPEG walk, result register.
// Depends on ihss_pkg, ihss_if and ihss_decode.
//
// Takes one byte a cycle and, on the byte marked last, delivers one result
// (format, width, height) through a result register. A spare result slot
// sits behind that register, so bytes keep flowing while one result waits;
// the input stalls only while two results wait, and its ready comes from a
// register, not from the output side. Per byte the work is a capture into
// the header bytes, a shift of the nine-byte JPEG window and one
// add-and-compare for the JPEG segment walk. The stream state returns to
// reset after each last byte; webp_enable is kept.
module image_header_size_sniffer
  import ihss_pkg::*;
#(
  parameter int HEADER_BYTES  = 40,
  parameter int POSITION_BITS = 32
) (
  input logic clk,
  input logic rst,
  ihss_in_if.sink    in_req,
  ihss_out_if.source out_res,
  ihss_cfg_if.sink   cfg
);

  localparam int HIDX = $clog2(HEADER_BYTES);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic                     webp_enable;
  logic [POSITION_BITS-1:0] byte_position;
  logic [7:0]               header_store [HEADER_BYTES];
  logic [7:0]               jpeg_window [9];
  logic [POSITION_BITS:0]   jpeg_next_segment;
  logic                     jpeg_found;
  logic [31:0]              jpeg_size_pair;
  logic                     res_valid;
  result_t                  res_q;
  logic                     skid_valid;
  result_t                  res_s;

  // Next values after the current request
  logic                     accept;
  logic                     push;
  logic                     pop;
  logic [POSITION_BITS-1:0] pos_next;
  logic [7:0]               hdr_next [HEADER_BYTES];
  logic [7:0]               win_next [9];
  logic [POSITION_BITS:0]   seg_next;
  logic                     found_next;
  logic [31:0]              pair_next;
  logic [POSITION_BITS+1:0] seg_sum;
  result_t                  res_d;

  assign in_req.ready = !skid_valid;
  assign accept       = in_req.valid && in_req.ready;
  assign push         = accept && in_req.last_byte;
  assign pop          = res_valid && out_res.ready;
  assign cfg.ready    = 1'b1;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_next[i] = header_store[i];
    end
    if (byte_position < POSITION_BITS'(HEADER_BYTES)) begin
      hdr_next[byte_position[HIDX-1:0]] = in_req.data_byte;
    end
    for (int i = 0; i < 8; i++) begin
      win_next[i] = jpeg_window[i+1];
    end
    win_next[8] = in_req.data_byte;

    pos_next   = byte_position;
    seg_next   = jpeg_next_segment;
    found_next = jpeg_found;
    pair_next  = jpeg_size_pair;
    seg_sum    = {1'b0, jpeg_next_segment} + (POSITION_BITS+2)'({win_next[2], win_next[3]})
               + (POSITION_BITS+2)'(2);
    if (byte_position != POS_MAX) begin
      pos_next = byte_position + 1'b1;
      if (!jpeg_found && {1'b0, byte_position} == jpeg_next_segment + (POSITION_BITS+1)'(8))
      begin
        if (win_next[0] == MARK_FF && win_next[1] >= SOF_LO && win_next[1] <= SOF_HI) begin
          found_next = 1'b1;
          pair_next  = {win_next[5], win_next[6], win_next[7], win_next[8]};
        end else if (seg_sum > {2'b0, POS_MAX} + (POSITION_BITS+2)'(1)) begin
          seg_next = {1'b1, {POSITION_BITS{1'b0}}};
        end else begin
          seg_next = seg_sum[POSITION_BITS:0];
        end
      end
    end
  end

  ihss_decode #(.HEADER_BYTES(HEADER_BYTES), .POSITION_BITS(POSITION_BITS)) u_dec (
    .hdr        (hdr_next),
    .size       (pos_next),
    .jpeg_found (found_next),
    .jpeg_pair  (pair_next),
    .webp_enable(webp_enable),
    .res        (res_d)
  );

  // Stream state: advance per request, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      jpeg_next_segment <= (POSITION_BITS+1)'(2);
      jpeg_found        <= 1'b0;
      jpeg_size_pair    <= '0;
    end else if (accept) begin
      if (in_req.last_byte) begin
        byte_position     <= '0;
        jpeg_next_segment <= (POSITION_BITS+1)'(2);
        jpeg_found        <= 1'b0;
        jpeg_size_pair    <= '0;
      end else begin
        byte_position     <= pos_next;
        jpeg_next_segment <= seg_next;
        jpeg_found        <= found_next;
        jpeg_size_pair    <= pair_next;
      end
    end
  end

  // Byte stores hold payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      header_store <= hdr_next;
      jpeg_window  <= win_next;
    end
  end

  // Result register and spare slot: fill the spare only while the head waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && res_valid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      res_q <= res_s;
    end else if (push && (!res_valid || pop)) begin
      res_q <= res_d;
    end
    if (push && res_valid && !pop) begin
      res_s <= res_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      webp_enable <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      webp_enable <= cfg.data;
    end
  end

  assign out_res.valid        = res_valid;
  assign out_res.image_format = res_q.fmt;
  assign out_res.image_width  = res_q.width;
  assign out_res.image_height = res_q.height;

  // No match always reports zero sizes
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_q.fmt == FMT_NONE |-> res_q.width == 32'd0 && res_q.height == 32'd0)
    else $error("nonzero size without a format");

  // Stream restarts after a last byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_req.last_byte |=> byte_position == '0 && !jpeg_found)
    else $error("stream state not cleared");

  // A waiting result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_res.ready |=> res_valid && $stable(res_q))
    else $error("result dropped");

  // The spare slot is only used behind a waiting result
  a_spare: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("spare slot filled with empty head");

  // The walk never moves once a frame header is found
  a_walk: assert property (@(posedge clk) disable iff (rst)
    jpeg_found && !(accept && in_req.last_byte) |=> $stable(jpeg_next_segment))
    else $error("walk moved after find");

endmodule

/* src/ihss_decode.sv */
// Header decoder: turns the captured header bytes and JPEG walk state into a result.
// Depends on ihss_pkg.
module ihss_decode
  import ihss_pkg::*;
#(
  parameter int HEADER_BYTES  = 40,
  parameter int POSITION_BITS = 32
) (
  input  logic [7:0]               hdr [HEADER_BYTES],
  input  logic [POSITION_BITS-1:0] size,
  input  logic                     jpeg_found,
  input  logic [31:0]              jpeg_pair,
  input  logic                     webp_enable,
  output result_t                  res
);

  function automatic logic [31:0] be32(input logic [7:0] a, b, c, d);
    be32 = {a, b, c, d};
  endfunction

  logic        png_ok, webp_ok, jpeg_ok;
  logic [31:0] png_w, png_h, webp_w, webp_h;
  logic [31:0] t0, t8, t12, t28, vl;
  logic [31:0] x24, x27;

  always_comb begin
    t0  = be32(hdr[0], hdr[1], hdr[2], hdr[3]);
    t8  = be32(hdr[8], hdr[9], hdr[10], hdr[11]);
    t12 = be32(hdr[12], hdr[13], hdr[14], hdr[15]);
    t28 = be32(hdr[28], hdr[29], hdr[30], hdr[31]);
    vl  = be32(hdr[24], hdr[23], hdr[22], hdr[21]);
    x24 = be32(8'h00, hdr[26], hdr[25], hdr[24]);
    x27 = be32(8'h00, hdr[29], hdr[28], hdr[27]);

    // PNG, plain or CgBI
    png_ok = 1'b0;
    png_w  = be32(hdr[16], hdr[17], hdr[18], hdr[19]);
    png_h  = be32(hdr[20], hdr[21], hdr[22], hdr[23]);
    if (size >= POSITION_BITS'(16) && t0 == TAG_PNG) begin
      if (t12 == TAG_IHDR) begin
        png_ok = size >= POSITION_BITS'(24);
      end else if (t12 == TAG_CGBI && size >= POSITION_BITS'(40) && t28 == TAG_IHDR) begin
        png_ok = 1'b1;
        png_w  = be32(hdr[32], hdr[33], hdr[34], hdr[35]);
        png_h  = be32(hdr[36], hdr[37], hdr[38], hdr[39]);
      end
    end

    // JPEG
    jpeg_ok = size >= POSITION_BITS'(2) && {hdr[0], hdr[1]} == TAG_SOI && jpeg_found;

    // WebP
    webp_ok = 1'b0;
    webp_w  = '0;
    webp_h  = '0;
    if (size >= POSITION_BITS'(16) && t0 == TAG_RIFF && t8 == TAG_WEBP) begin
      if (t12 == TAG_VP8 && size >= POSITION_BITS'(30)) begin
        webp_ok = 1'b1;
        webp_w  = {18'd0, {hdr[27][5:0], hdr[26]} & MASK14};
        webp_h  = {18'd0, {hdr[29][5:0], hdr[28]} & MASK14};
      end else if (t12 == TAG_VP8L && size >= POSITION_BITS'(25)) begin
        webp_ok = 1'b1;
        webp_w  = {18'd0, vl[13:0]} + 32'd1;
        webp_h  = {18'd0, vl[27:14]} + 32'd1;
      end else if (t12 == TAG_VP8X && size >= POSITION_BITS'(30)) begin
        if ((hdr[20] & VP8X_RSV) == 8'h00 && (hdr[20] & VP8X_BIT) == 8'h00) begin
          webp_ok = 1'b1;
          webp_w  = x24 + 32'd1;
          webp_h  = x27 + 32'd1;
        end
      end
    end

    // Pick by priority
    if (png_ok) begin
      res = '{fmt: FMT_PNG, width: png_w, height: png_h};
    end else if (jpeg_ok) begin
      res = '{fmt: FMT_JPEG, width: {16'd0, jpeg_pair[15:0]},
              height: {16'd0, jpeg_pair[31:16]}};
    end else if (webp_enable && webp_ok) begin
      res = '{fmt: FMT_WEBP, width: webp_w, height: webp_h};
    end else begin
      res = '{fmt: FMT_NONE, width: 32'd0, height: 32'd0};
    end
  end

endmodule

/* dv/image_header_size_sniffer_tb.sv */
// Testbench for image_header_size_sniffer: streams PNG, JPEG, WebP and noise files
// and checks each header result against an in-bench predictor.
// Depends on ihss_pkg, ihss_if and the block itself.
`timescale 1ns / 1ps

module image_header_size_sniffer_tb
  import ihss_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  logic clk = 1'b1;
  logic rst = 1'b1;

  ihss_in_if  in_req ();
  ihss_out_if out_res ();
  ihss_cfg_if cfg ();

  image_header_size_sniffer u_top (
    .clk(clk), .rst(rst), .in_req(in_req), .out_res(out_res), .cfg(cfg)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor state
  logic        sn_webp_en;
  logic [7:0]  sn_hdr [0:39];
  logic [7:0]  sn_win [0:8];
  logic [32:0] sn_pos;
  logic [32:0] sn_next_seg;
  logic        sn_jpg_found;
  logic [31:0] sn_jpg_pair;

  result_t     size_expect_q [$];
  byte_req_t   pending_bytes [$];

  byte_req_t   drv_req;
  byte_req_t   mon_req;
  result_t     exp_res;
  logic        in_taken = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_active = 1'b0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          files_sent = 0;
  int          bytes_queued = 0;
  int          cycle_count = 0;
  int          fmt_count [4];

  function automatic void clear_sniff_state();
    sn_pos = 33'd0;
    for (int i = 0; i < 40; i++) sn_hdr[i] = 8'h00;
    for (int i = 0; i < 9; i++) sn_win[i] = 8'h00;
    sn_next_seg = 33'd2;
    sn_jpg_found = 1'b0;
    sn_jpg_pair = 32'h0;
  endfunction

  function automatic logic [31:0] hdr_be32(int p);
    return {sn_hdr[p], sn_hdr[p+1], sn_hdr[p+2], sn_hdr[p+3]};
  endfunction

  function automatic logic [31:0] hdr_le32(int p);
    return {sn_hdr[p+3], sn_hdr[p+2], sn_hdr[p+1], sn_hdr[p]};
  endfunction

  // Advance the predictor by one byte; push a result on the last byte
  function automatic void predict_header_byte(byte_req_t r);
    logic [32:0] idx;
    logic [32:0] nxt;
    result_t     res;
    logic [31:0] n;
    idx = sn_pos;
    if (idx < 33'd40) sn_hdr[idx] = r.data_byte;
    for (int i = 0; i < 8; i++) sn_win[i] = sn_win[i+1];
    sn_win[8] = r.data_byte;
    if (idx < 33'hFFFF_FFFF) begin
      sn_pos = idx + 33'd1;
      if (!sn_jpg_found && idx == sn_next_seg + 33'd8) begin
        if (sn_win[0] == MARK_FF && sn_win[1] >= SOF_LO && sn_win[1] <= SOF_HI) begin
          sn_jpg_found = 1'b1;
          sn_jpg_pair = {sn_win[5], sn_win[6], sn_win[7], sn_win[8]};
        end else begin
          nxt = sn_next_seg + 33'({sn_win[2], sn_win[3]}) + 33'd2;
          if (nxt > 33'h1_0000_0000) nxt = 33'h1_0000_0000;
          sn_next_seg = nxt;
        end
      end
    end
    if (!r.last_byte) return;
    res = '{fmt: FMT_NONE, width: 32'h0, height: 32'h0};
    if (sn_pos >= 16 && hdr_be32(0) == TAG_PNG && hdr_be32(12) == TAG_IHDR && sn_pos >= 24)
    begin
      res = '{fmt: FMT_PNG, width: hdr_be32(16), height: hdr_be32(20)};
    end else if (sn_pos >= 40 && hdr_be32(0) == TAG_PNG && hdr_be32(12) == TAG_CGBI &&
                 hdr_be32(28) == TAG_IHDR) begin
      res = '{fmt: FMT_PNG, width: hdr_be32(32), height: hdr_be32(36)};
    end else if (sn_pos >= 2 && {sn_hdr[0], sn_hdr[1]} == TAG_SOI && sn_jpg_found) begin
      res = '{fmt: FMT_JPEG, width: {16'h0, sn_jpg_pair[15:0]},
              height: {16'h0, sn_jpg_pair[31:16]}};
    end else if (sn_webp_en && sn_pos >= 16 && hdr_be32(0) == TAG_RIFF &&
                 hdr_be32(8) == TAG_WEBP) begin
      if (hdr_be32(12) == TAG_VP8 && sn_pos >= 30) begin
        res = '{fmt: FMT_WEBP,
                width: {18'h0, sn_hdr[27][5:0], sn_hdr[26]},
                height: {18'h0, sn_hdr[29][5:0], sn_hdr[28]}};
      end else if (hdr_be32(12) == TAG_VP8L && sn_pos >= 25) begin
        n = hdr_le32(21);
        res = '{fmt: FMT_WEBP, width: {18'h0, n[13:0]} + 32'd1,
                height: {18'h0, n[27:14]} + 32'd1};
      end else if (hdr_be32(12) == TAG_VP8X && sn_pos >= 30 &&
                   (sn_hdr[20] & VP8X_RSV) == 8'h00 && (sn_hdr[20] & VP8X_BIT) == 8'h00) begin
        res = '{fmt: FMT_WEBP, width: (hdr_le32(24) & 32'h00FF_FFFF) + 32'd1,
                height: (hdr_le32(27) & 32'h00FF_FFFF) + 32'd1};
      end
    end
    size_expect_q.push_back(res);
    clear_sniff_state();
  endfunction

  // File builders: append one file's bytes to the pending queue
  task automatic push_file(input logic [7:0] bytes [$]);
    byte_req_t r;
    for (int i = 0; i < bytes.size(); i++) begin
      r.data_byte = bytes[i];
      r.last_byte = (i == bytes.size() - 1);
      pending_bytes.push_back(r);
    end
    bytes_queued += bytes.size();
    files_sent++;
  endtask

  function automatic void put32(ref logic [7:0] b [$], input logic [31:0] v, input bit be);
    if (be) begin
      b.push_back(v[31:24]); b.push_back(v[23:16]); b.push_back(v[15:8]); b.push_back(v[7:0]);
    end else begin
      b.push_back(v[7:0]); b.push_back(v[15:8]); b.push_back(v[23:16]); b.push_back(v[31:24]);
    end
  endfunction

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Randomly flip or cut a well-formed file
  function automatic void mangle(ref logic [7:0] b [$]);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0 && b.size() > 1) begin
      b = b[0:$urandom_range(0, b.size() - 1)];
    end else if (k == 1) begin
      b[$urandom_range(0, b.size() - 1)] = rnd8();
    end
  endfunction

  task automatic png_file(input logic [31:0] w, input logic [31:0] h, input bit cgbi,
                          input int trail);
    logic [7:0] b [$];
    put32(b, TAG_PNG, 1); put32(b, 32'h0D0A1A0A, 1); put32(b, 32'd13, 1);
    if (cgbi) begin
      put32(b, TAG_CGBI, 1); put32(b, rnd32(), 1); put32(b, rnd32(), 1);
      put32(b, rnd32(), 1); put32(b, TAG_IHDR, 1);
    end else begin
      put32(b, TAG_IHDR, 1);
    end
    put32(b, w, 1); put32(b, h, 1);
    for (int i = 0; i < trail; i++) b.push_back(rnd8());
    mangle(b);
    push_file(b);
  endtask

  // JPEG: random segments, some short to exercise overlap, then an SOF
  task automatic jpeg_file(input int nseg);
    logic [7:0] b [$];
    int         len;
    int         tail;
    b.push_back(8'hFF); b.push_back(8'hD8);
    for (int s = 0; s < nseg; s++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 20);
      b.push_back(8'hFF); b.push_back(8'($urandom_range(8'hC3, 8'hFE)));
      b.push_back(len[15:8]); b.push_back(len[7:0]);
      for (int i = 0; i < len - 2; i++) b.push_back(rnd8());
      if (len < 2) break;
    end
    b.push_back(8'hFF); b.push_back(8'($urandom_range(SOF_LO, SOF_HI)));
    b.push_back(8'h00); b.push_back(8'h11); b.push_back(8'h08);
    put32(b, rnd32(), 1);
    tail = $urandom_range(0, 6);
    for (int i = 0; i < tail; i++) b.push_back(rnd8());
    mangle(b);
    push_file(b);
  endtask

  task automatic webp_file(input int kind, input logic [31:0] a, input logic [31:0] c);
    logic [7:0] b [$];
    int         tail;
    put32(b, TAG_RIFF, 1); put32(b, rnd32(), 0); put32(b, TAG_WEBP, 1);
    if (kind == 0) begin
      put32(b, TAG_VP8, 1);
      for (int i = 16; i < 26; i++) b.push_back(rnd8());
      b.push_back(a[7:0]); b.push_back(a[15:8]); b.push_back(c[7:0]); b.push_back(c[15:8]);
    end else if (kind == 1) begin
      put32(b, TAG_VP8L, 1);
      for (int i = 16; i < 21; i++) b.push_back(rnd8());
      put32(b, a, 0);
    end else begin
      put32(b, TAG_VP8X, 1); put32(b, rnd32(), 0);
      b.push_back($urandom_range(0, 3) == 0 ? rnd8() : (rnd8() & 8'h3E));
      b.push_back(rnd8()); b.push_back(rnd8()); b.push_back(rnd8());
      b.push_back(a[7:0]); b.push_back(a[15:8]); b.push_back(a[23:16]);
      b.push_back(c[7:0]); b.push_back(c[15:8]); b.push_back(c[23:16]);
    end
    tail = $urandom_range(0, 4);
    for (int i = 0; i < tail; i++) b.push_back(rnd8());
    mangle(b);
    push_file(b);
  endtask

  task automatic noise_file(input int n);
    logic [7:0] b [$];
    for (int i = 0; i < n; i++) b.push_back(rnd8());
    push_file(b);
  endtask

  task automatic random_file();
    case ($urandom_range(0, 9))
      0, 1:    png_file(rnd32(), rnd32(), $urandom_range(0, 3) == 0, $urandom_range(0, 8));
      2, 3, 4: jpeg_file($urandom_range(0, 4));
      5, 6, 7: webp_file($urandom_range(0, 2), rnd32(), rnd32());
      default: noise_file($urandom_range(1, 45));
    endcase
  endtask

  // Queue whole files until about the given number of bytes is added
  task automatic fill_bytes(input int target);
    int base;
    base = bytes_queued;
    while (bytes_queued - base < target) random_file();
  endtask

  // Wait until the driver has drained and every result has come back
  task automatic drain();
    while (pending_bytes.size() != 0 || in_req.valid || size_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_webp_enable(input logic v);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.data  = v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sn_webp_en = v;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Long receiver hold-off, counted here once started
  initial begin
    wait (hold_go);
    hold_active = 1'b1;
    for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
    hold_active = 1'b0;
  end

  // Driver: offer pending requests at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_req.valid     <= 1'b0;
      in_req.data_byte <= 8'h00;
      in_req.last_byte <= 1'b0;
    end else if (!in_req.valid || in_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_req = pending_bytes.pop_front();
        in_req.valid     <= 1'b1;
        in_req.data_byte <= drv_req.data_byte;
        in_req.last_byte <= drv_req.last_byte;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // Receiver: drive ready at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: check results, then advance the predictor on accepted bytes
  always @(posedge clk) begin
    in_taken <= !rst && in_req.valid && in_req.ready;
    if (!rst) begin
      if (out_res.valid && out_res.ready) begin
        if (size_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected no result, got fmt %0d w %0d h %0d",
                     out_res.image_format, out_res.image_width, out_res.image_height);
        end else begin
          exp_res = size_expect_q.pop_front();
          if (out_res.image_format !== exp_res.fmt || out_res.image_width !== exp_res.width ||
              out_res.image_height !== exp_res.height) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected fmt %0d w %0d h %0d, got fmt %0d w %0d h %0d",
                       exp_res.fmt, exp_res.width, exp_res.height, out_res.image_format,
                       out_res.image_width, out_res.image_height);
          end
          fmt_count[exp_res.fmt]++;
          results_seen++;
        end
      end
      if (in_req.valid && in_req.ready) begin
        mon_req.data_byte = in_req.data_byte;
        mon_req.last_byte = in_req.last_byte;
        predict_header_byte(mon_req);
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding",
               size_expect_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    cfg.valid = 1'b0;
    cfg.data  = 1'b0;
    sn_webp_en = 1'b1;
    clear_sniff_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Slow sender, slower receiver, with a long hold-off at the start
    send_idle_pct = 32;
    recv_idle_pct = 56;
    hold_go = 1'b1;
    fill_bytes(700);
    drain();

    // WebP off, idling swapped
    write_webp_enable(1'b0);
    send_idle_pct = 56;
    recv_idle_pct = 32;
    fill_bytes(650);
    drain();

    // WebP on, full rate
    write_webp_enable(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_bytes(650);
    drain();

    $display("streamed %0d bytes in %0d files, %0d results checked, %0d mismatches",
             bytes_queued, files_sent, results_seen, mismatches);
    $display("formats seen: none %0d, png %0d, jpeg %0d, webp %0d; webp toggled off and on",
             fmt_count[0], fmt_count[1], fmt_count[2], fmt_count[3]);
    if (mismatches == 0 && size_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
src/ihss_pkg.sv
src/ihss_if.sv
src/ihss_decode.sv
src/image_header_size_sniffer.sv
dv/image_header_size_sniffer_tb.sv
